@@ rtl/hft_pkg.sv @@
// Package for the heading familiarity table: sizes, score constants,
// command codes and the types shared by the cell chain and the head unit.
// No dependencies.
package hft_pkg;

    localparam int BINS       = 36;
    localparam int IDX_W      = $clog2(BINS);
    localparam int BIN_W      = 6;
    localparam int SCORE_W    = 16;
    localparam int COUNT_W    = 32;
    localparam int HEAD_W     = 13;
    localparam int HEADING_W  = 16;

    localparam logic [SCORE_W-1:0] SCORE_ONE      = 16'd32768;
    localparam logic [SCORE_W-1:0] SCORE_STEP     = 16'd3277;
    localparam logic [SCORE_W-1:0] CURIOSITY_BASE = 16'd49152;
    localparam logic [SCORE_W-1:0] DECAY_RESET    = 16'd64881;

    // heading / 100 as multiply by ceil(2^22 / 100), exact for 15-bit inputs
    localparam int BIN_SPAN    = 100;
    localparam int BIN_HALF    = 50;
    localparam int RECIP_SHIFT = 22;
    localparam logic [15:0] RECIP = 16'd41944;

    typedef enum logic [1:0] {
        CMD_RECORD = 2'd0,
        CMD_DECAY  = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_LEAST  = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [COUNT_W-1:0] count;
    } t_cell;

    typedef struct packed {
        t_cmd cmd;
        logic hit;
    } t_proc_ctl;

endpackage

@@ rtl/hft_if.sv @@
// Valid/ready channel interfaces for command words and result words.
// Depends on hft_pkg for field widths.
interface hft_in_if
    import hft_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [1:0]           cmd;
    logic [HEADING_W-1:0] heading_tenths;

    modport source (output valid, cmd, heading_tenths, input ready);
    modport sink   (input valid, cmd, heading_tenths, output ready);
endinterface

interface hft_out_if
    import hft_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [BIN_W-1:0]   bin_index;
    logic [SCORE_W-1:0] familiarity;
    logic [COUNT_W-1:0] detections;
    logic [SCORE_W-1:0] curiosity;
    logic [HEAD_W-1:0]  least_heading_tenths;

    modport source (output valid, bin_index, familiarity, detections, curiosity,
                    least_heading_tenths, input ready);
    modport sink   (input valid, bin_index, familiarity, detections, curiosity,
                    least_heading_tenths, output ready);
endinterface

@@ rtl/hft_cell.sv @@
// One storage cell of the bin ring: a score and a detection count that
// move to the neighbor cell on every shift. Depends on hft_pkg.
module hft_cell
    import hft_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_shift,
    input  t_cell i_d,
    output t_cell o_q
);

    t_cell r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

@@ rtl/hft_proc.sv @@
// Head unit of the ring: updates the bin passing the head cell for
// record and decay, and flags a new minimum for the least search.
// Depends on hft_pkg.
module hft_proc
    import hft_pkg::*;
(
    input  t_proc_ctl          i_ctl,
    input  t_cell              i_cell,
    input  logic [SCORE_W-1:0] i_decay,
    input  logic [SCORE_W-1:0] i_lowest,
    output t_cell              o_cell,
    output logic               o_take
);

    logic [2*SCORE_W-1:0] w_mul;
    logic [SCORE_W:0]     w_sum;

    assign w_mul  = i_cell.score * i_decay;
    assign w_sum  = {1'b0, i_cell.score} + {1'b0, SCORE_STEP};
    assign o_take = i_cell.score < i_lowest;

    always_comb begin
        o_cell = i_cell;
        unique case (i_ctl.cmd)
            CMD_RECORD: begin
                if (i_ctl.hit) begin
                    o_cell.score = (w_sum > {1'b0, SCORE_ONE}) ? SCORE_ONE
                                                              : w_sum[SCORE_W-1:0];
                    if (!(&i_cell.count)) begin
                        o_cell.count = i_cell.count + 1'b1;
                    end
                end
            end
            CMD_DECAY: begin
                o_cell.score = w_mul[2*SCORE_W-1:SCORE_W];
            end
            CMD_QUERY, CMD_LEAST: begin
                o_cell = i_cell;
            end
            default: begin
                o_cell = i_cell;
            end
        endcase
    end

endmodule

@@ rtl/heading_familiarity_table_core.sv @@
// Heading familiarity table top level: command channel, ring of bin cells,
// head unit and result register. Depends on hft_pkg, hft_if, hft_cell,
// hft_proc.
//
// Usage: command words (cmd, heading_tenths) come in on i_cmd_ch, one result
// word per command leaves on o_res_ch. The decay factor is written through
// i_cfg_we / i_cfg_data while the block is idle.
// The bins sit in a ring of BINS cells; each command rotates the ring once,
// one bin a cycle past the head unit, and then loads the result register;
// ready comes back together with the valid result word, so a new command is
// taken only after the last command's result has been loaded.
// i_cmd_ch.ready is high only while no rotation runs.
// A new command is taken while a result still waits; if that command's
// rotation ends before the receiver takes the earlier word, the block holds
// until the result register frees up. A stalled result holds steady.
// Reset (i_rst_n low, synchronous) clears all scores and counts, restores
// the decay factor to its default and empties the result register.
module heading_familiarity_table_core
    import hft_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [SCORE_W-1:0] i_cfg_data,
    hft_in_if.sink             i_cmd_ch,
    hft_out_if.source          o_res_ch
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    t_state             r_state;
    t_cmd               r_cmd;
    logic [IDX_W-1:0]   r_bin;
    logic [IDX_W-1:0]   r_idx;
    logic [IDX_W-1:0]   r_pick;
    logic [SCORE_W-1:0] r_lowest;
    logic [SCORE_W-1:0] r_decay;
    t_cell              r_res;

    logic               r_o_valid;
    logic [BIN_W-1:0]   r_o_bin;
    logic [SCORE_W-1:0] r_o_fam;
    logic [COUNT_W-1:0] r_o_det;
    logic [SCORE_W-1:0] r_o_cur;
    logic [HEAD_W-1:0]  r_o_least;

    // heading to bin
    logic [14:0]        w_mag;
    logic [30:0]        w_prod;
    logic [8:0]         w_quot;
    logic [IDX_W-1:0]   w_bin;

    assign w_mag  = i_cmd_ch.heading_tenths[14:0];
    assign w_prod = w_mag * RECIP;
    assign w_quot = w_prod[30:RECIP_SHIFT];

    always_comb begin
        if (i_cmd_ch.heading_tenths[HEADING_W-1]) begin
            w_bin = '0;
        end else if (w_quot > 9'(BINS - 1)) begin
            w_bin = IDX_W'(BINS - 1);
        end else begin
            w_bin = w_quot[IDX_W-1:0];
        end
    end

    // ring of cells; cell 0 is the head, the head unit feeds the last cell
    t_cell     w_q [BINS];
    t_cell     w_next;
    logic      w_take;
    logic      w_shift;
    t_proc_ctl w_ctl;

    assign w_shift   = (r_state == ST_RUN);
    assign w_ctl.cmd = r_cmd;
    assign w_ctl.hit = (r_idx == r_bin);

    for (genvar k = 0; k < BINS; k++) begin : g_cell
        t_cell w_d;
        if (k == BINS - 1) begin : g_tail
            assign w_d = w_next;
        end else begin : g_link
            assign w_d = w_q[k+1];
        end
        hft_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_d     (w_d),
            .o_q     (w_q[k])
        );
    end

    hft_proc u_proc (
        .i_ctl    (w_ctl),
        .i_cell   (w_q[0]),
        .i_decay  (r_decay),
        .i_lowest (r_lowest),
        .o_cell   (w_next),
        .o_take   (w_take)
    );

    logic w_accept;
    logic w_out_free;

    assign w_accept   = i_cmd_ch.valid && i_cmd_ch.ready;
    assign w_out_free = !r_o_valid || o_res_ch.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_o_valid <= 1'b0;
            r_decay   <= DECAY_RESET;
            r_idx     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_decay <= i_cfg_data;
            end
            // in ST_DONE a taken word is replaced by the new one below
            if (r_o_valid && o_res_ch.ready && r_state != ST_DONE) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_cmd    <= t_cmd'(i_cmd_ch.cmd);
                        r_bin    <= w_bin;
                        r_idx    <= '0;
                        r_lowest <= SCORE_ONE;
                        r_state  <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (r_cmd == CMD_LEAST) begin
                        // bin 0 is the answer when nothing is below 1.0
                        if (r_idx == '0 || w_take) begin
                            r_res  <= w_q[0];
                            r_pick <= r_idx;
                        end
                        if (w_take) begin
                            r_lowest <= w_q[0].score;
                        end
                    end else if (r_idx == r_bin) begin
                        r_res  <= w_next;
                        r_pick <= r_idx;
                    end
                    if (r_idx == IDX_W'(BINS - 1)) begin
                        r_idx   <= '0;
                        r_state <= ST_DONE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_bin   <= BIN_W'(r_pick);
                        r_o_fam   <= r_res.score;
                        r_o_det   <= r_res.count;
                        r_o_cur   <= CURIOSITY_BASE - r_res.score;
                        r_o_least <= (r_cmd == CMD_LEAST)
                                     ? HEAD_W'(r_pick * BIN_SPAN + BIN_HALF) : '0;
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign i_cmd_ch.ready                = (r_state == ST_IDLE);
    assign o_res_ch.valid                = r_o_valid;
    assign o_res_ch.bin_index            = r_o_bin;
    assign o_res_ch.familiarity          = r_o_fam;
    assign o_res_ch.detections           = r_o_det;
    assign o_res_ch.curiosity            = r_o_cur;
    assign o_res_ch.least_heading_tenths = r_o_least;

endmodule

@@ rtl/hft_checker.sv @@
// Port-level checker for the heading familiarity table, bound to the top
// level. Depends on hft_pkg.
module hft_checker
    import hft_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [BIN_W-1:0]   i_bin,
    input logic [SCORE_W-1:0] i_fam,
    input logic [COUNT_W-1:0] i_det,
    input logic [SCORE_W-1:0] i_cur,
    input logic [HEAD_W-1:0]  i_least
);

    // one command at a time: ready drops right after a word is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("command accepted while busy");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_bin)
            && $stable(i_fam) && $stable(i_det) && $stable(i_least))
        else $error("stalled result changed");

    a_curiosity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> SCORE_W'(i_fam + i_cur) == CURIOSITY_BASE)
        else $error("curiosity does not match familiarity");

    a_least_heading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_least != '0 |->
            i_least == HEAD_W'(i_bin * BIN_SPAN + BIN_HALF))
        else $error("least heading does not match bin");

    a_score_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_fam <= SCORE_ONE)
        else $error("score above 1.0");

endmodule

bind heading_familiarity_table_core hft_checker u_hft_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cmd_ch.valid),
    .i_in_ready  (i_cmd_ch.ready),
    .i_out_valid (o_res_ch.valid),
    .i_out_ready (o_res_ch.ready),
    .i_bin       (o_res_ch.bin_index),
    .i_fam       (o_res_ch.familiarity),
    .i_det       (o_res_ch.detections),
    .i_cur       (o_res_ch.curiosity),
    .i_least     (o_res_ch.least_heading_tenths)
);

@@ tb/sv/hft_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for the heading familiarity table: keeps its own copy of the bin
// scores, counts and decay factor, predicts every result word and compares.
// Depends on hft_pkg and the hft_in_if / hft_out_if channel interfaces.
module hft_scoreboard
    import hft_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [SCORE_W-1:0] i_cfg_data,
    hft_in_if                  i_cmd_mon,
    hft_out_if                 i_res_mon,
    output int                 o_fail_count,
    output int                 o_outstanding
);

    typedef struct packed {
        logic [BIN_W-1:0]   bin_index;
        logic [SCORE_W-1:0] familiarity;
        logic [COUNT_W-1:0] detections;
        logic [SCORE_W-1:0] curiosity;
        logic [HEAD_W-1:0]  least_heading_tenths;
    } t_bin_report;

    logic [SCORE_W-1:0] score_mirror [BINS];
    logic [COUNT_W-1:0] count_mirror [BINS];
    logic [SCORE_W-1:0] decay_mult;
    t_bin_report        pending_reports [$];
    int                 fail_total = 0;

    assign o_fail_count = fail_total;

    initial o_outstanding = 0;

    function automatic int heading_to_bin(logic [HEADING_W-1:0] raw);
        logic signed [HEADING_W-1:0] h;
        int b;
        h = raw;
        if (h < 0) return 0;
        b = int'(h) / BIN_SPAN;
        if (b > BINS - 1) b = BINS - 1;
        return b;
    endfunction

    function automatic t_bin_report report_for(int bin, logic [HEAD_W-1:0] least);
        t_bin_report r;
        r.bin_index            = bin[BIN_W-1:0];
        r.familiarity          = score_mirror[bin];
        r.detections           = count_mirror[bin];
        r.curiosity            = CURIOSITY_BASE - score_mirror[bin];
        r.least_heading_tenths = least;
        return r;
    endfunction

    function automatic void check_field(string name, logic [COUNT_W-1:0] expv,
                                        logic [COUNT_W-1:0] actv);
        if (expv !== actv) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, expv, actv);
            fail_total++;
        end
    endfunction

    task automatic apply_command(input t_cmd cmd, input logic [HEADING_W-1:0] heading);
        int                 bin;
        int                 pick;
        logic [SCORE_W-1:0] lowest;
        logic [SCORE_W:0]   raised;
        logic [31:0]        product;
        bin = heading_to_bin(heading);
        case (cmd)
            CMD_RECORD: begin
                raised = {1'b0, score_mirror[bin]} + SCORE_STEP;
                score_mirror[bin] = (raised > SCORE_ONE) ? SCORE_ONE : raised[SCORE_W-1:0];
                // count sticks at all ones
                if (count_mirror[bin] != '1) count_mirror[bin]++;
                pending_reports.push_back(report_for(bin, '0));
            end
            CMD_DECAY: begin
                for (int i = 0; i < BINS; i++) begin
                    product = 32'(score_mirror[i]) * 32'(decay_mult);
                    score_mirror[i] = product[31:16];
                end
                pending_reports.push_back(report_for(bin, '0));
            end
            CMD_QUERY: begin
                pending_reports.push_back(report_for(bin, '0));
            end
            CMD_LEAST: begin
                // first strictly lower score wins; a full table reports bin 0
                lowest = SCORE_ONE;
                pick   = 0;
                for (int i = 0; i < BINS; i++) begin
                    if (score_mirror[i] < lowest) begin
                        lowest = score_mirror[i];
                        pick   = i;
                    end
                end
                pending_reports.push_back(report_for(pick, HEAD_W'(pick * BIN_SPAN + BIN_HALF)));
            end
            default: begin
                pending_reports.push_back(report_for(bin, '0));
            end
        endcase
    endtask

    task automatic check_result();
        t_bin_report want;
        if (pending_reports.size() == 0) begin
            $display("%0t ns: result word with nothing pending, expected none, actual bin %0d",
                     $time, i_res_mon.bin_index);
            fail_total++;
        end else begin
            want = pending_reports.pop_front();
            check_field("bin_index", want.bin_index, i_res_mon.bin_index);
            check_field("familiarity", want.familiarity, i_res_mon.familiarity);
            check_field("detections", want.detections, i_res_mon.detections);
            check_field("curiosity", want.curiosity, i_res_mon.curiosity);
            check_field("least_heading_tenths", want.least_heading_tenths,
                        i_res_mon.least_heading_tenths);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < BINS; i++) begin
                score_mirror[i] = '0;
                count_mirror[i] = '0;
            end
            decay_mult = DECAY_RESET;
            pending_reports.delete();
        end else begin
            if (i_cfg_we) decay_mult = i_cfg_data;
            // retire before predicting, so the oldest word is compared first
            if (i_res_mon.valid && i_res_mon.ready) check_result();
            if (i_cmd_mon.valid && i_cmd_mon.ready)
                apply_command(t_cmd'(i_cmd_mon.cmd), i_cmd_mon.heading_tenths);
        end
        o_outstanding <= pending_reports.size();
    end

endmodule

@@ tb/sv/tb_heading_familiarity_table_core.sv @@
`timescale 1ns / 100ps
// Top of the heading familiarity table testbench: clock, reset, command and
// decay-factor stimulus, result back-pressure and the final verdict.
// Depends on hft_pkg, hft_if, heading_familiarity_table_core and hft_scoreboard.
module tb_heading_familiarity_table_core;
    import hft_pkg::*;

    localparam int LATENCY       = BINS + 2;
    localparam int MAX_IDLE      = 12;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_WORDS   = 33;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               cfg_we;
    logic [SCORE_W-1:0] cfg_data;
    bit                 no_idle;
    int                 fail_count;
    int                 outstanding;
    int                 cycle_count;
    int                 sent_by_cmd [4] = '{default: 0};
    int                 settings_used = 0;

    hft_in_if  cmd_ch ();
    hft_out_if res_ch ();

    heading_familiarity_table_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_cmd_ch   (cmd_ch),
        .o_res_ch   (res_ch)
    );

    hft_scoreboard u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_data    (cfg_data),
        .i_cmd_mon     (cmd_ch),
        .i_res_mon     (res_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int idle_draw();
        return no_idle ? 0 : $urandom_range(0, MAX_IDLE);
    endfunction

    task automatic send_command(input t_cmd cmd, input logic [HEADING_W-1:0] heading);
        int gap;
        gap = idle_draw();
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_ch.valid          <= 1'b1;
        cmd_ch.cmd            <= cmd;
        cmd_ch.heading_tenths <= heading;
        do @(posedge i_clk); while (!(cmd_ch.valid && cmd_ch.ready));
        sent_by_cmd[cmd]++;
    endtask

    // hold the sender until every pending result word is out
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_decay(input logic [SCORE_W-1:0] factor);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= factor;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic t_cmd random_cmd();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return CMD_RECORD;
        if (r < 6) return CMD_DECAY;
        if (r < 8) return CMD_QUERY;
        return CMD_LEAST;
    endfunction

    function automatic logic [HEADING_W-1:0] random_heading(bit hot, int hot_base);
        logic [HEADING_W-1:0] corners [6];
        int r;
        corners = '{16'h8000, 16'hFFFF, 16'h0000, 16'd3599, 16'd3600, 16'h7FFF};
        r = $urandom_range(0, 9);
        if (hot && r < 7)
            return HEADING_W'((hot_base + $urandom_range(0, 3)) * BIN_SPAN
                              + $urandom_range(0, BIN_SPAN - 1));
        if (r < 7) return HEADING_W'($urandom_range(0, BINS * BIN_SPAN - 1));
        if (r < 9) return HEADING_W'($urandom);
        return corners[$urandom_range(0, 5)];
    endfunction

    // result side back-pressure
    initial begin
        int stall;
        res_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = idle_draw();
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_ch.valid && res_ch.ready));
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d result words still pending",
                 cycle_count, outstanding);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        logic [SCORE_W-1:0] factor;
        bit                 hot;
        int                 hot_base;
        i_rst_n               <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_data              <= '0;
        cmd_ch.valid          <= 1'b0;
        cmd_ch.cmd            <= CMD_QUERY;
        cmd_ch.heading_tenths <= '0;
        no_idle               <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, heading clamps, bin edges, record saturation
        send_command(CMD_LEAST, 16'd0);
        send_command(CMD_QUERY, 16'h8000);
        send_command(CMD_RECORD, 16'h7FFF);
        send_command(CMD_RECORD, 16'hFFFF);
        send_command(CMD_RECORD, 16'd0);
        send_command(CMD_RECORD, 16'd99);
        send_command(CMD_RECORD, 16'd100);
        send_command(CMD_RECORD, 16'd3599);
        send_command(CMD_RECORD, 16'd3600);
        send_command(CMD_QUERY, 16'd3550);
        send_command(CMD_DECAY, 16'd0);
        send_command(CMD_LEAST, 16'd0);
        repeat (11) send_command(CMD_RECORD, 16'd1250);
        send_command(CMD_QUERY, 16'd1299);
        send_command(CMD_DECAY, 16'h8000);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0:       factor = 16'h0000;
                1:       factor = 16'hFFFF;
                2:       factor = DECAY_RESET;
                3:       factor = 16'h0001;
                4:       factor = 16'h8000;
                default: factor = SCORE_W'($urandom);
            endcase
            set_decay(factor);
            no_idle  <= (p % 4 == 3);
            hot      = (p % 2 == 0);
            hot_base = $urandom_range(0, BINS - 4);
            repeat (PHASE_WORDS) send_command(random_cmd(), random_heading(hot, hot_base));
        end

        // clear every score, then fill every bin to 1.0 in order, asking for
        // the least familiar bin after each one
        set_decay(16'h0000);
        send_command(CMD_DECAY, HEADING_W'($urandom));
        set_decay(16'hFFFF);
        for (int b = 0; b < BINS; b++) begin
            no_idle <= (b % 3 == 0);
            repeat (11) begin
                if (b < BINS - 1)
                    send_command(CMD_RECORD,
                                 HEADING_W'(b * BIN_SPAN + $urandom_range(0, BIN_SPAN - 1)));
                else
                    send_command(CMD_RECORD,
                                 HEADING_W'($urandom_range((BINS - 1) * BIN_SPAN, 32767)));
            end
            send_command(CMD_LEAST, HEADING_W'($urandom));
        end
        no_idle <= 1'b0;
        send_command(CMD_DECAY, 16'd500);
        send_command(CMD_LEAST, 16'd0);
        send_command(CMD_RECORD, 16'd0);
        send_command(CMD_LEAST, 16'd0);
        send_command(CMD_QUERY, 16'd0);
        set_decay(DECAY_RESET);
        send_command(CMD_DECAY, 16'd1800);

        drain();
        repeat (LATENCY) @(posedge i_clk);
        $display("Covered %0d command words: %0d record, %0d decay, %0d query, %0d least",
                 sent_by_cmd[CMD_RECORD] + sent_by_cmd[CMD_DECAY] + sent_by_cmd[CMD_QUERY]
                 + sent_by_cmd[CMD_LEAST], sent_by_cmd[CMD_RECORD], sent_by_cmd[CMD_DECAY],
                 sent_by_cmd[CMD_QUERY], sent_by_cmd[CMD_LEAST]);
        $display("over %0d decay factor writes incl. 0 and 65535, full-table scans, %0d errors",
                 settings_used, fail_count);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
